@@ rtl/blpg_pkg.sv @@
// -----------------------------------------------------------------------------
// Ball lattice point generator package
// Widths, register indexes, sequencer codes and coordinate helpers.
// -----------------------------------------------------------------------------
package blpg_pkg;

   localparam int MAX_N_DEF  = 255;
   localparam int SUB_W      = 8;
   localparam int RADIUS_W   = 24;
   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 27;
   localparam int SLOT_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [SUB_W-1:0]    SUB_RST    = SUB_W'(2);
   localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(65536);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(7);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SUBINTERVALS = 3'd0,
      CSR_RADIUS       = 3'd1,
      CSR_CENTER_X     = 3'd2,
      CSR_CENTER_Y     = 3'd3,
      CSR_CENTER_Z     = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_MUL,
      ST_DIV
   } state_type;

   typedef enum logic [3:0] {
      ACT_STALL,
      ACT_DONE,
      ACT_FINISH,
      ACT_NEXT_PLANE,
      ACT_NEXT_ROW,
      ACT_NEXT_CELL,
      ACT_SKIP,
      ACT_LOAD,
      ACT_EMIT
   } act_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   // mirrored axes per slot: bit 0 x, bit 1 y, bit 2 z
   function automatic logic [2:0] slot_axes(input logic [2:0] slot);
      logic [2:0] axes;
      case (slot)
         3'd0: axes = 3'b000;
         3'd1: axes = 3'b001;
         3'd2: axes = 3'b010;
         3'd3: axes = 3'b100;
         3'd4: axes = 3'b011;
         3'd5: axes = 3'b101;
         3'd6: axes = 3'b110;
         default: axes = 3'b111;
      endcase
      return axes;
   endfunction

   // center +/- offset, clamped to the signed coordinate range
   function automatic logic [COORD_W-1:0] sat_coord(
      input logic [COORD_W-1:0]  center,
      input logic [RADIUS_W-1:0] off,
      input logic                mirror
   );
      logic [COORD_W:0] c_ext;
      logic [COORD_W:0] o_ext;
      logic [COORD_W:0] sum;
      logic [COORD_W-1:0] res;
      c_ext = {center[COORD_W-1], center};
      o_ext = (COORD_W+1)'(off);
      sum   = mirror ? (c_ext - o_ext) : (c_ext + o_ext);
      if (sum[COORD_W] != sum[COORD_W-1]) begin
         res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         res = sum[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/blpg_req_if.sv @@
// -----------------------------------------------------------------------------
// Ball lattice point generator request channel
// Valid/ready channel carrying the restart flag.
// -----------------------------------------------------------------------------
interface blpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/blpg_rsp_if.sv @@
// -----------------------------------------------------------------------------
// Ball lattice point generator response channel
// Valid/ready channel carrying one generated point.
// -----------------------------------------------------------------------------
interface blpg_rsp_if
   import blpg_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic [INDEX_W-1:0]        point_index;
   logic                      point_valid;

   modport source (
      output valid, output point_x, output point_y, output point_z,
      output point_index, output point_valid, input ready
   );
   modport sink (
      input valid, input point_x, input point_y, input point_z,
      input point_index, input point_valid, output ready
   );
endinterface

@@ rtl/ball_lattice_point_generator_unit.sv @@
// -----------------------------------------------------------------------------
// Ball lattice point generator
// Walks the cell grid of a ball and returns one mirrored lattice point per
// request, from a small sequencer around one shared restoring divider.
// -----------------------------------------------------------------------------
// Each request returns exactly one response: the next point of the walk, or a
// not-valid response once the grid is done. A request steps through every
// mirror slot, cell, row or plane skipped on the way. The axis offsets
// trunc(radius*2m/(2n+1)) come from one shared divider that handles one
// quotient bit per cycle. The z offset is redone at every new cell, the y
// offset at every new row and the x offset at every new plane, and all three
// after a restart or a register write. The response sits in an output
// register; the block takes a new request once it has placed the previous
// response there.
// -----------------------------------------------------------------------------
module ball_lattice_point_generator_unit
   import blpg_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   blpg_req_if.sink              req_chan,
   blpg_rsp_if.source            rsp_chan
);

   localparam int NW   = $clog2(MAX_N + 1);
   localparam int IW   = $clog2(MAX_N + 2);
   localparam int CW   = (NW > SUB_W) ? NW : SUB_W;
   localparam int LW   = NW + 1;
   localparam int SQW  = 2 * IW;
   localparam int SW   = SQW + 2;
   localparam int DW   = RADIUS_W + IW + 1;
   localparam int CNTW = $clog2(DW + 1);

   // configuration
   logic [SUB_W-1:0]    sub_ff, sub_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [COORD_W-1:0]  cx_ff, cx_in;
   logic [COORD_W-1:0]  cy_ff, cy_in;
   logic [COORD_W-1:0]  cz_ff, cz_in;

   // walk state
   state_type           state_ff, state_in;
   logic [IW-1:0]       i_ff, i_in;
   logic [IW-1:0]       j_ff, j_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [SQW-1:0]      isq_ff, isq_in;
   logic [SQW-1:0]      jsq_ff, jsq_in;
   logic [SQW-1:0]      ksq_ff, ksq_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [INDEX_W-1:0]  count_ff, count_in;
   logic                fin_ff, fin_in;
   logic                oki_ff, oki_in;
   logic                okj_ff, okj_in;
   logic                okk_ff, okk_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // divider and payload
   axis_type            sel_ff, sel_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]       prod_ff, prod_in;
   logic [LW-1:0]       rem_ff, rem_in;
   logic [RADIUS_W-1:0] quo_ff, quo_in;
   logic [RADIUS_W-1:0] offi_ff, offi_in;
   logic [RADIUS_W-1:0] offj_ff, offj_in;
   logic [RADIUS_W-1:0] offk_ff, offk_in;
   logic [SW-1:0]       nn_ff, nn_in;
   logic [COORD_W-1:0]  px_ff, px_in;
   logic [COORD_W-1:0]  py_ff, py_in;
   logic [COORD_W-1:0]  pz_ff, pz_in;
   logic [INDEX_W-1:0]  pidx_ff, pidx_in;
   logic                pval_ff, pval_in;

   logic [CW-1:0]       sub_ext;
   logic [CW-1:0]       n_full;
   logic [NW-1:0]       n;
   logic [IW-1:0]       n_idx;
   logic [LW-1:0]       lim;
   logic [2*LW-1:0]     nn_prod;
   logic [SW-1:0]       sq_sum;
   logic [2:0]          have;
   logic [2:0]          axes;
   logic                out_free;
   logic                req_acc;
   act_type             act;
   logic [IW-1:0]       m_sel;
   logic [LW:0]         trial;
   logic                ge;

   assign sub_ext = CW'(sub_ff);
   assign n_full  = (sub_ext > CW'(MAX_N)) ? CW'(MAX_N) : sub_ext;
   assign n       = n_full[NW-1:0];
   assign n_idx   = IW'(n);
   assign lim     = {n, 1'b1};
   assign nn_prod = LW'(n) * (LW'(n) + LW'(1));
   assign nn_in   = SW'(nn_prod);
   assign sq_sum  = SW'(isq_ff) + SW'(jsq_ff) + SW'(ksq_ff);
   assign have    = {k_ff != '0, j_ff != '0, i_ff != '0};
   assign axes    = slot_axes(slot_ff[2:0]);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && (state_ff == ST_IDLE);

   assign trial = {rem_ff, prod_ff[DW-1]};
   assign ge    = (trial >= {1'b0, lim});

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.point_x     = px_ff;
   assign rsp_chan.point_y     = py_ff;
   assign rsp_chan.point_z     = pz_ff;
   assign rsp_chan.point_index = pidx_ff;
   assign rsp_chan.point_valid = pval_ff;

   // walk decision for the current cell and slot
   always_comb begin
      if (fin_ff) begin
         act = out_free ? ACT_DONE : ACT_STALL;
      end else if (i_ff > n_idx) begin
         act = out_free ? ACT_FINISH : ACT_STALL;
      end else if (j_ff > n_idx) begin
         act = ACT_NEXT_PLANE;
      end else if (k_ff > n_idx) begin
         act = ACT_NEXT_ROW;
      end else if (slot_ff > LAST_SLOT) begin
         act = ACT_NEXT_CELL;
      end else if ((radius_ff != '0) && (sq_sum > nn_ff)) begin
         act = ACT_NEXT_ROW;
      end else if ((axes & have) != axes) begin
         act = ACT_SKIP;
      end else if (!(oki_ff && okj_ff && okk_ff)) begin
         act = ACT_LOAD;
      end else begin
         act = out_free ? ACT_EMIT : ACT_STALL;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_WALK;
         end
         ST_WALK: begin
            case (act)
               ACT_EMIT, ACT_DONE, ACT_FINISH: state_in = ST_IDLE;
               ACT_LOAD: state_in = ST_MUL;
               default: state_in = ST_WALK;
            endcase
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNTW'(1)) state_in = ST_WALK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      sub_in       = sub_ff;
      radius_in    = radius_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      isq_in       = isq_ff;
      jsq_in       = jsq_ff;
      ksq_in       = ksq_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      fin_in       = fin_ff;
      oki_in       = oki_ff;
      okj_in       = okj_ff;
      okk_in       = okk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      offi_in      = offi_ff;
      offj_in      = offj_ff;
      offk_in      = offk_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pz_in        = pz_ff;
      pidx_in      = pidx_ff;
      pval_in      = pval_ff;
      m_sel        = k_ff;

      if (csr_we) begin
         oki_in = 1'b0;
         okj_in = 1'b0;
         okk_in = 1'b0;
         case (csr_index)
            CSR_SUBINTERVALS: sub_in    = csr_wdata[SUB_W-1:0];
            CSR_RADIUS:       radius_in = csr_wdata[RADIUS_W-1:0];
            CSR_CENTER_X:     cx_in     = csr_wdata[COORD_W-1:0];
            CSR_CENTER_Y:     cy_in     = csr_wdata[COORD_W-1:0];
            CSR_CENTER_Z:     cz_in     = csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_chan.restart) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               isq_in   = '0;
               jsq_in   = '0;
               ksq_in   = '0;
               slot_in  = '0;
               count_in = '0;
               fin_in   = 1'b0;
               oki_in   = 1'b0;
               okj_in   = 1'b0;
               okk_in   = 1'b0;
            end
         end
         ST_WALK: begin
            case (act)
               ACT_DONE, ACT_FINISH: begin
                  fin_in       = 1'b1;
                  rsp_valid_in = 1'b1;
                  px_in        = '0;
                  py_in        = '0;
                  pz_in        = '0;
                  pidx_in      = '0;
                  pval_in      = 1'b0;
               end
               ACT_NEXT_PLANE: begin
                  i_in    = i_ff + IW'(1);
                  isq_in  = isq_ff + SQW'({i_ff, 1'b1});
                  j_in    = '0;
                  jsq_in  = '0;
                  k_in    = '0;
                  ksq_in  = '0;
                  slot_in = '0;
                  oki_in  = 1'b0;
                  okj_in  = 1'b0;
                  okk_in  = 1'b0;
               end
               ACT_NEXT_ROW: begin
                  j_in    = j_ff + IW'(1);
                  jsq_in  = jsq_ff + SQW'({j_ff, 1'b1});
                  k_in    = '0;
                  ksq_in  = '0;
                  slot_in = '0;
                  okj_in  = 1'b0;
                  okk_in  = 1'b0;
               end
               ACT_NEXT_CELL: begin
                  k_in    = k_ff + IW'(1);
                  ksq_in  = ksq_ff + SQW'({k_ff, 1'b1});
                  slot_in = '0;
                  okk_in  = 1'b0;
               end
               ACT_SKIP: slot_in = slot_ff + SLOT_W'(1);
               ACT_LOAD: begin
                  if (!oki_ff) begin
                     sel_in = AXIS_X;
                  end else if (!okj_ff) begin
                     sel_in = AXIS_Y;
                  end else begin
                     sel_in = AXIS_Z;
                  end
               end
               ACT_EMIT: begin
                  rsp_valid_in = 1'b1;
                  px_in        = sat_coord(cx_ff, offi_ff, axes[0]);
                  py_in        = sat_coord(cy_ff, offj_ff, axes[1]);
                  pz_in        = sat_coord(cz_ff, offk_ff, axes[2]);
                  pidx_in      = count_ff;
                  pval_in      = 1'b1;
                  count_in     = count_ff + INDEX_W'(1);
                  slot_in      = slot_ff + SLOT_W'(1);
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            case (sel_ff)
               AXIS_X:  m_sel = i_ff;
               AXIS_Y:  m_sel = j_ff;
               default: m_sel = k_ff;
            endcase
            prod_in = DW'(radius_ff) * DW'({m_sel, 1'b0});
            rem_in  = '0;
            quo_in  = '0;
            cnt_in  = CNTW'(DW);
         end
         ST_DIV: begin
            rem_in  = ge ? LW'(trial - {1'b0, lim}) : trial[LW-1:0];
            quo_in  = {quo_ff[RADIUS_W-2:0], ge};
            prod_in = prod_ff << 1;
            cnt_in  = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               case (sel_ff)
                  AXIS_X: begin
                     offi_in = {quo_ff[RADIUS_W-2:0], ge};
                     oki_in  = 1'b1;
                  end
                  AXIS_Y: begin
                     offj_in = {quo_ff[RADIUS_W-2:0], ge};
                     okj_in  = 1'b1;
                  end
                  default: begin
                     offk_in = {quo_ff[RADIUS_W-2:0], ge};
                     okk_in  = 1'b1;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= SUB_RST;
         radius_ff    <= RADIUS_RST;
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         isq_ff       <= '0;
         jsq_ff       <= '0;
         ksq_ff       <= '0;
         slot_ff      <= '0;
         count_ff     <= '0;
         fin_ff       <= 1'b0;
         oki_ff       <= 1'b0;
         okj_ff       <= 1'b0;
         okk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= AXIS_X;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         radius_ff    <= radius_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         isq_ff       <= isq_in;
         jsq_ff       <= jsq_in;
         ksq_ff       <= ksq_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         fin_ff       <= fin_in;
         oki_ff       <= oki_in;
         okj_ff       <= okj_in;
         okk_ff       <= okk_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      offi_ff <= offi_in;
      offj_ff <= offj_in;
      offk_ff <= offk_in;
      nn_ff   <= nn_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      pz_ff   <= pz_in;
      pidx_ff <= pidx_in;
      pval_ff <= pval_in;
   end

endmodule
